// File: hdl/vmps_pkg.sv
package vmps_pkg;

    // geometry
    localparam int GRID     = 256;
    localparam int GRID_LG2 = $clog2(GRID);
    localparam int SCREEN_W = 256;
    localparam int SCREEN_H = 256;
    localparam int SW_LG2   = $clog2(SCREEN_W);
    localparam int SH_LG2   = $clog2(SCREEN_H);
    localparam int FS_DEPTH = SCREEN_W * SCREEN_H;
    localparam int FS_AW    = $clog2(FS_DEPTH);

    // field widths
    localparam int OP_W   = 2;
    localparam int VOX_W  = 8;
    localparam int DENS_W = 16;
    localparam int RC_W   = 8;
    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int CIDX_W = 4;
    localparam int FRAC   = 12;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    // register file
    localparam int NREGS  = 8;
    localparam int REG_AW = $clog2(NREGS);
    localparam logic [REG_AW-1:0] REG_X_CX  = 3'd0;
    localparam logic [REG_AW-1:0] REG_X_CY  = 3'd1;
    localparam logic [REG_AW-1:0] REG_X_CZ  = 3'd2;
    localparam logic [REG_AW-1:0] REG_X_OFF = 3'd3;
    localparam logic [REG_AW-1:0] REG_Y_CX  = 3'd4;
    localparam logic [REG_AW-1:0] REG_Y_CY  = 3'd5;
    localparam logic [REG_AW-1:0] REG_Y_CZ  = 3'd6;
    localparam logic [REG_AW-1:0] REG_Y_OFF = 3'd7;

    // arithmetic widths: p = 2c - GRID, products, projected numerator
    localparam int P_W    = GRID_LG2 + 2;
    localparam int PROD_W = COEF_W + P_W;
    localparam int NUM_W  = PROD_W + 3;
    // numerator / 2^(FRAC+1+GRID_LG2) scaled by screen size
    localparam int X_SH   = FRAC + 1 + GRID_LG2 - SW_LG2;
    localparam int Y_SH   = FRAC + 1 + GRID_LG2 - SH_LG2;

    // MAC sequencing
    localparam int MAC_STEPS = 3;
    localparam int STEP_W    = 2;

    // op codes
    localparam logic [OP_W-1:0] OP_SPLAT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic              load;
        logic              mac_en;
        logic [STEP_W-1:0] mac_sel;
        logic              proj;
        logic              addr_en;
        logic              rd_en;
        logic              resolve;
        logic              clr_en;
        logic              peak_clr;
        logic              out_load;
    } vmps_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            dens_zero;
        logic            clr_last;
    } vmps_sts_t;

endpackage

// File: hdl/voxel_max_projection_splat.sv
// Sequence: splat: decode, MAC, projection, address, read, write-back; read: no MAC or
//   projection; clear: store sweep; zero-density splat or op 3: straight to output.
// Throughput: one transaction at a time, taken only when idle, paced by the 3-step shared MAC,
//   the projection and address stages and the registered frame-store read-modify-write.
// Reset: asynchronous, active low; then the whole store is swept to zero, no input.
// Configuration writes are accepted in every cycle, including during the sweep.
module voxel_max_projection_splat (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vox_x[7:0], vox_y[15:8], vox_z[23:16], density[39:24],
    // read_col[47:40], read_row[55:48]
    input  logic [55:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_value[15:0], frame_peak[31:16]
    output logic [31:0] m_axis_tdata,
    // landed[0]
    output logic [0:0]  m_axis_tuser,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import vmps_pkg::*;

    vmps_cmd_t cmd;
    vmps_sts_t sts;
    logic      landed;

    // register file never stalls a write transaction
    assign cfg_ready = 1'b1;

    // sequencer: sweep, decode, MAC steps, projection, RMW, output hand-off
    vmps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // projection arithmetic, frame store, peak and result registers
    vmps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata),
        .out_user  (landed)
    );

    assign m_axis_tuser = landed;

endmodule

// File: hdl/vmps_ctrl.sv
module vmps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output vmps_pkg::vmps_cmd_t cmd,
    input  vmps_pkg::vmps_sts_t sts
);
    import vmps_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_MAC  = 4'd3;
    localparam logic [3:0] S_PROJ = 4'd4;
    localparam logic [3:0] S_ADDR = 4'd5;
    localparam logic [3:0] S_RD   = 4'd6;
    localparam logic [3:0] S_WR   = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              clr_op_reg, clr_op_next;
    logic              out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        clr_op_next = clr_op_reg;
        cmd         = '0;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.peak_clr = 1'b1;
                    clr_op_next  = 1'b0;
                    state_next   = clr_op_reg ? S_OUT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                case (sts.op)
                    OP_SPLAT:
                    begin
                        step_next  = '0;
                        state_next = sts.dens_zero ? S_OUT : S_MAC;
                    end
                    OP_READ:  state_next = S_ADDR;
                    OP_CLEAR:
                    begin
                        clr_op_next = 1'b1;
                        state_next  = S_CLR;
                    end
                    default:  state_next = S_OUT;
                endcase
            end
            S_MAC:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = step_reg;
                if (step_reg == STEP_W'(MAC_STEPS - 1))
                    state_next = S_PROJ;
                else
                    step_next = step_reg + 1'b1;
            end
            S_PROJ:
            begin
                cmd.proj   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                cmd.addr_en = 1'b1;
                state_next  = S_RD;
            end
            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            step_reg      <= '0;
            clr_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_op_reg    <= clr_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while pending");

    // a result appears only from a load
    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.out_load))
        else $error("output valid without a load");

endmodule

// File: hdl/vmps_dp.sv
module vmps_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  vmps_pkg::vmps_cmd_t                   cmd,
    output vmps_pkg::vmps_sts_t                   sts,
    input  logic [vmps_pkg::IN_DATA_W-1:0]        in_data,
    input  logic [vmps_pkg::OP_W-1:0]             in_user,
    input  logic                                  cfg_valid,
    input  logic [vmps_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [vmps_pkg::COEF_W-1:0]           cfg_data,
    output logic [vmps_pkg::OUT_DATA_W-1:0]       out_data,
    output logic                                  out_user
);
    import vmps_pkg::*;

    localparam logic signed [NUM_W-1:0] BIAS  = NUM_W'((1 << FRAC) * GRID);
    localparam logic signed [NUM_W-1:0] RND_X = NUM_W'((1 << X_SH) - 1);
    localparam logic signed [NUM_W-1:0] RND_Y = NUM_W'((1 << Y_SH) - 1);
    localparam logic signed [NUM_W-1:0] RND_0 = NUM_W'(0);
    localparam int OFF_SH = GRID_LG2 + 1;

    logic signed [COEF_W-1:0] coef_reg [NREGS];

    logic [OP_W-1:0]          op_reg;
    logic signed [P_W-1:0]    px_reg, py_reg, pz_reg;
    logic [DENS_W-1:0]        dens_reg;
    logic [RC_W-1:0]          rcol_reg, rrow_reg;
    logic signed [NUM_W-1:0]  acc_x_reg, acc_y_reg;
    logic signed [NUM_W-1:0]  num_x_reg, num_y_reg;
    logic [FS_AW-1:0]         addr_reg;
    logic                     inb_reg;
    logic [PIX_W-1:0]         rd_reg;
    logic [PIX_W-1:0]         pix_res_reg;
    logic                     landed_res_reg;
    logic [PIX_W-1:0]         peak_reg;
    logic [FS_AW-1:0]         clr_cnt_reg;
    logic [PIX_W-1:0]         out_pix_reg, out_peak_reg;
    logic                     out_landed_reg;

    logic [PIX_W-1:0]         fs_mem [FS_DEPTH];

    // MAC operand select
    logic signed [COEF_W-1:0] csel_x, csel_y;
    logic signed [P_W-1:0]    psel;
    logic signed [PROD_W-1:0] prod_x, prod_y;

    always_comb
    begin
        case (cmd.mac_sel)
            2'd0:
            begin
                csel_x = coef_reg[REG_X_CX];
                csel_y = coef_reg[REG_Y_CX];
                psel   = px_reg;
            end
            2'd1:
            begin
                csel_x = coef_reg[REG_X_CY];
                csel_y = coef_reg[REG_Y_CY];
                psel   = py_reg;
            end
            default:
            begin
                csel_x = coef_reg[REG_X_CZ];
                csel_y = coef_reg[REG_Y_CZ];
                psel   = pz_reg;
            end
        endcase
    end

    assign prod_x = PROD_W'(csel_x) * PROD_W'(psel);
    assign prod_y = PROD_W'(csel_y) * PROD_W'(psel);

    // truncate toward zero, then bounds check
    logic signed [NUM_W-1:0] qx, qy;
    logic                    inb_x, inb_y, inb_rd;

    assign qx = (num_x_reg + (num_x_reg[NUM_W-1] ? RND_X : RND_0)) >>> X_SH;
    assign qy = (num_y_reg + (num_y_reg[NUM_W-1] ? RND_Y : RND_0)) >>> Y_SH;
    assign inb_x  = !qx[NUM_W-1] && (qx < $signed(NUM_W'(SCREEN_W)));
    assign inb_y  = !qy[NUM_W-1] && (qy < $signed(NUM_W'(SCREEN_H)));
    assign inb_rd = (32'(rcol_reg) < 32'(SCREEN_W)) && (32'(rrow_reg) < 32'(SCREEN_H));

    // max update
    logic [PIX_W-1:0] new_val;
    logic             splat_wr;
    assign new_val  = (dens_reg > rd_reg) ? dens_reg : rd_reg;
    assign splat_wr = cmd.resolve && (op_reg == OP_SPLAT) && inb_reg;

    logic             fs_we;
    logic [FS_AW-1:0] fs_wa;
    logic [PIX_W-1:0] fs_wd;
    assign fs_we = cmd.clr_en || splat_wr;
    assign fs_wa = cmd.clr_en ? clr_cnt_reg : addr_reg;
    assign fs_wd = cmd.clr_en ? '0 : new_val;

    always_ff @(posedge clk)
    begin
        if (fs_we)
            fs_mem[fs_wa] <= fs_wd;
        if (cmd.rd_en)
            rd_reg <= fs_mem[addr_reg];
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
                coef_reg[i] <= (i == int'(REG_X_CX) || i == int'(REG_Y_CY)) ?
                               COEF_W'(1 << FRAC) : '0;
            clr_cnt_reg <= '0;
            peak_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && (cfg_index < CIDX_W'(NREGS)))
                coef_reg[cfg_index[REG_AW-1:0]] <= cfg_data;
            if (cmd.clr_en)
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
            if (cmd.peak_clr)
                peak_reg <= '0;
            else if (splat_wr && (new_val > peak_reg))
                peak_reg <= new_val;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= in_user;
            px_reg         <= $signed(P_W'({in_data[7:0], 1'b0})) - $signed(P_W'(GRID));
            py_reg         <= $signed(P_W'({in_data[15:8], 1'b0})) - $signed(P_W'(GRID));
            pz_reg         <= $signed(P_W'({in_data[23:16], 1'b0})) - $signed(P_W'(GRID));
            dens_reg       <= in_data[39:24];
            rcol_reg       <= in_data[47:40];
            rrow_reg       <= in_data[55:48];
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            pix_res_reg    <= '0;
            landed_res_reg <= 1'b0;
        end
        if (cmd.mac_en)
        begin
            acc_x_reg <= acc_x_reg + NUM_W'(prod_x);
            acc_y_reg <= acc_y_reg + NUM_W'(prod_y);
        end
        if (cmd.proj)
        begin
            num_x_reg <= acc_x_reg + (NUM_W'(coef_reg[REG_X_OFF]) <<< OFF_SH) + BIAS;
            num_y_reg <= acc_y_reg + (NUM_W'(coef_reg[REG_Y_OFF]) <<< OFF_SH) + BIAS;
        end
        if (cmd.addr_en)
        begin
            if (op_reg == OP_READ)
            begin
                addr_reg <= FS_AW'(rrow_reg) * FS_AW'(SCREEN_W) + FS_AW'(rcol_reg);
                inb_reg  <= inb_rd;
            end
            else
            begin
                addr_reg <= FS_AW'(qy) * FS_AW'(SCREEN_W) + FS_AW'(qx);
                inb_reg  <= inb_x && inb_y;
            end
        end
        if (cmd.resolve)
        begin
            if (splat_wr)
            begin
                pix_res_reg    <= new_val;
                landed_res_reg <= 1'b1;
            end
            else if (op_reg == OP_READ)
                pix_res_reg <= inb_reg ? rd_reg : '0;
        end
        if (cmd.out_load)
        begin
            out_pix_reg    <= pix_res_reg;
            out_landed_reg <= landed_res_reg;
            out_peak_reg   <= peak_reg;
        end
    end

    assign sts.op        = op_reg;
    assign sts.dens_zero = (dens_reg == '0);
    assign sts.clr_last  = (clr_cnt_reg == FS_AW'(FS_DEPTH - 1));

    assign out_data = {out_peak_reg, out_pix_reg};
    assign out_user = out_landed_reg;

    // a landed splat leaves the peak at or above the stored value
    a_peak_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        splat_wr |=> (peak_reg >= $past(new_val)) && (pix_res_reg == $past(new_val)))
        else $error("peak or result lost a landed splat");

    // sweep counter wraps to zero at the end of a clear
    a_sweep_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.clr_en && sts.clr_last) |=> (clr_cnt_reg == '0) && (peak_reg == '0))
        else $error("clear sweep did not finish cleanly");

endmodule

// File: tb/sv/voxel_max_projection_splat_tb.sv
`timescale 1ns / 1ps

module voxel_max_projection_splat_tb;

    import vmps_pkg::*;

    // op 3 has no meaning in the block: it must leave all state alone
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam int N_PHASES     = 10;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int TAIL_CYCLES  = 20;
    localparam int MAX_REPORTS  = 10;
    localparam int HOT_DEPTH    = 32;
    localparam int RECENT_DEPTH = 16;

    // one input transaction, unpacked from tdata/tuser
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VOX_W-1:0]  vox_x;
        logic [VOX_W-1:0]  vox_y;
        logic [VOX_W-1:0]  vox_z;
        logic [DENS_W-1:0] density;
        logic [RC_W-1:0]   read_col;
        logic [RC_W-1:0]   read_row;
    } vox_item_t;

    // one result transaction
    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             landed;
        logic [PIX_W-1:0] frame_peak;
    } pix_result_t;

    // Frame-store shadow: tracks projection registers, every pixel and the
    // running peak, and queues the result each accepted transaction must produce.
    class mip_scoreboard;
        logic [COEF_W-1:0] coef [NREGS];
        logic [PIX_W-1:0]  frame [FS_DEPTH];
        logic [PIX_W-1:0]  peak;
        pix_result_t       pending_pixels [$];
        logic [RC_W-1:0]   hot_col [$];
        logic [RC_W-1:0]   hot_row [$];
        int                mismatches;

        function new();
            coef = '{16'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0};
            foreach (frame[i])
                frame[i] = '0;
            peak       = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [COEF_W-1:0] val);
            if (idx < NREGS)
                coef[idx] = val;
        endfunction

        // affine row applied to doubled centred coords, one truncation toward zero
        function longint project_axis(int base, longint p2 [3], longint dim);
            longint s;
            longint off;
            longint num;
            s = 0;
            for (int k = 0; k < 3; k++)
                s += longint'($signed(coef[base + k])) * p2[k];
            off = longint'($signed(coef[base + 3]));
            num = s + 2 * longint'(GRID) * off + 4096 * longint'(GRID);
            return (dim * num) / (8192 * longint'(GRID));
        endfunction

        function void note_item(vox_item_t it);
            pix_result_t want;
            longint      p2 [3];
            longint      col;
            longint      row;
            int          idx;
            want = '0;
            case (it.op)
                OP_SPLAT:
                begin
                    if (it.density != 0)
                    begin
                        p2[0] = 2 * longint'(it.vox_x) - GRID;
                        p2[1] = 2 * longint'(it.vox_y) - GRID;
                        p2[2] = 2 * longint'(it.vox_z) - GRID;
                        col = project_axis(REG_X_CX, p2, SCREEN_W);
                        row = project_axis(REG_Y_CX, p2, SCREEN_H);
                        if (col >= 0 && row >= 0 && col < SCREEN_W && row < SCREEN_H)
                        begin
                            idx = int'(row) * SCREEN_W + int'(col);
                            if (it.density > frame[idx])
                                frame[idx] = it.density;
                            if (frame[idx] > peak)
                                peak = frame[idx];
                            want.pixel_value = frame[idx];
                            want.landed      = 1'b1;
                            hot_col.push_back(RC_W'(col));
                            hot_row.push_back(RC_W'(row));
                            if (hot_col.size() > HOT_DEPTH)
                            begin
                                void'(hot_col.pop_front());
                                void'(hot_row.pop_front());
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    if (it.read_col < SCREEN_W && it.read_row < SCREEN_H)
                        want.pixel_value = frame[int'(it.read_row) * SCREEN_W
                                                 + int'(it.read_col)];
                end
                OP_CLEAR:
                begin
                    foreach (frame[i])
                        frame[i] = '0;
                    peak = '0;
                    hot_col.delete();
                    hot_row.delete();
                end
                default:
                begin
                end
            endcase
            want.frame_peak = peak;
            pending_pixels.push_back(want);
        endfunction

        function void check_result(pix_result_t got);
            pix_result_t want;
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected result: pix %0d landed %0d peak %0d",
                             $realtime, got.pixel_value, got.landed, got.frame_peak);
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pixel_value !== want.pixel_value || got.landed !== want.landed
                || got.frame_peak !== want.frame_peak)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] result mismatch: expected pix %0d landed %0d peak %0d",
                             $realtime, want.pixel_value, want.landed, want.frame_peak);
                    $display("    got pix %0d landed %0d peak %0d",
                             got.pixel_value, got.landed, got.frame_peak);
                end
            end
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CIDX_W-1:0]     cfg_index;
    logic [COEF_W-1:0]     cfg_data;

    mip_scoreboard           sb;
    bit                      idle_en;      // random idle bursts on both sides
    int                      cycle_count;
    logic [3*VOX_W-1:0]      recent_vox [$];  // {z, y, x} of recent splats
    logic [COEF_W-1:0]       regset [NREGS];
    int                      phase_items [N_PHASES] =
        '{260, 200, 200, 120, 120, 220, 220, 200, 140, 200};

    voxel_max_projection_splat i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog: covers the post-reset sweep, four clears and all stalls many times over
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("voxel_max_projection_splat test failed");
        $finish;
    end

    // result side: random stall bursts while idling is enabled
    initial
    begin
        int stall;
        stall         = 0;
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                stall--;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                stall         = $urandom_range(0, 9);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // result monitor: sampled at the rising edge, checked in arrival order
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result('{m_axis_tdata[15:0], m_axis_tuser[0], m_axis_tdata[31:16]});
    end

    function automatic vox_item_t mk_item(logic [OP_W-1:0] op, int x, int y, int z,
                                          int dens, int col, int row);
        vox_item_t it;
        it.op       = op;
        it.vox_x    = VOX_W'(x);
        it.vox_y    = VOX_W'(y);
        it.vox_z    = VOX_W'(z);
        it.density  = DENS_W'(dens);
        it.read_col = RC_W'(col);
        it.read_row = RC_W'(row);
        return it;
    endfunction

    // Random transaction: mostly splats, with voxel reuse and small windows so
    // pixels get hit repeatedly; reads favor pixels that recently landed.
    function automatic vox_item_t roll_item();
        vox_item_t it;
        int        pick;
        int        k;
        it.op       = OP_SPLAT;
        it.vox_x    = VOX_W'($urandom);
        it.vox_y    = VOX_W'($urandom);
        it.vox_z    = VOX_W'($urandom);
        it.density  = DENS_W'($urandom);
        it.read_col = RC_W'($urandom);
        it.read_row = RC_W'($urandom);
        pick        = $urandom_range(0, 99);
        if (pick < 60 || pick >= 95)
        begin
            k = $urandom_range(0, 9);
            if (pick >= 95 && recent_vox.size() > 0)
                {it.vox_z, it.vox_y, it.vox_x} = recent_vox[$];  // back-to-back same voxel
            else if (k < 4 && recent_vox.size() > 0)
                {it.vox_z, it.vox_y, it.vox_x} =
                    recent_vox[$urandom_range(0, recent_vox.size() - 1)];
            else if (k < 6)
            begin
                it.vox_x = VOX_W'($urandom_range(0, 15));
                it.vox_y = VOX_W'($urandom_range(0, 15));
                it.vox_z = VOX_W'($urandom_range(0, 15));
            end
            k = $urandom_range(0, 9);
            if (k == 0)
                it.density = '0;
            else if (k == 1)
                it.density = '1;
            else if (k < 4)
                it.density = DENS_W'($urandom_range(1, 255));
            recent_vox.push_back({it.vox_z, it.vox_y, it.vox_x});
            if (recent_vox.size() > RECENT_DEPTH)
                void'(recent_vox.pop_front());
        end
        else if (pick < 90)
        begin
            it.op = OP_READ;
            if (sb.hot_col.size() > 0 && $urandom_range(0, 2) != 0)
            begin
                k           = $urandom_range(0, sb.hot_col.size() - 1);
                it.read_col = sb.hot_col[k];
                it.read_row = sb.hot_row[k];
            end
        end
        else
            it.op = OP_NONE;
        return it;
    endfunction

    function automatic void fill_regset(int ph);
        regset = '{16'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0};
        case (ph)
            1:
            begin
                // half the frame pushed off each edge
                regset[REG_X_OFF] = -16'sd2048;
                regset[REG_Y_OFF] = 16'sd2048;
            end
            2:
            begin
                // screen x from voxel y, screen y from voxel z
                regset[REG_X_CX] = '0;
                regset[REG_X_CY] = 16'd4096;
                regset[REG_Y_CY] = '0;
                regset[REG_Y_CZ] = 16'd4096;
            end
            3:
                foreach (regset[i])
                    regset[i] = 16'h7FFF;
            4:
                foreach (regset[i])
                    regset[i] = 16'h8000;
            5, 6:
            begin
                foreach (regset[i])
                    regset[i] = COEF_W'($urandom_range(0, 12288) - 6144);
                regset[REG_X_OFF] = COEF_W'($urandom_range(0, 4096) - 2048);
                regset[REG_Y_OFF] = COEF_W'($urandom_range(0, 4096) - 2048);
            end
            7:
                foreach (regset[i])
                    regset[i] = COEF_W'($urandom);
            8:
            begin
                // mirrored x, y as a blend of voxel y and z
                regset[REG_X_CX] = -16'sd4096;
                regset[REG_Y_CY] = 16'd2048;
                regset[REG_Y_CZ] = 16'd2048;
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic send_item(input vox_item_t it);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {it.read_row, it.read_col, it.density, it.vox_z, it.vox_y, it.vox_x};
        s_axis_tuser  = it.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(it);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb            = new();
        idle_en       = 1'b1;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SPLAT;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset registers give an identity map: pixel (x, y)
        send_item(mk_item(OP_READ, 1, 2, 3, 4, 0, 0));              // empty store
        send_item(mk_item(OP_SPLAT, 0, 0, 0, 1, 255, 255));         // low corner
        send_item(mk_item(OP_SPLAT, 255, 255, 255, 65535, 0, 0));   // high corner, top density
        send_item(mk_item(OP_SPLAT, 255, 255, 0, 100, 0, 0));       // lower value keeps max
        send_item(mk_item(OP_SPLAT, 10, 20, 7, 0, 10, 20));         // zero density skipped
        send_item(mk_item(OP_SPLAT, 10, 20, 0, 500, 0, 0));
        send_item(mk_item(OP_SPLAT, 10, 20, 99, 300, 0, 0));        // z ignored by the map
        send_item(mk_item(OP_SPLAT, 10, 20, 1, 700, 0, 0));         // raise in place
        send_item(mk_item(OP_READ, 0, 0, 0, 0, 10, 20));            // read right after write
        send_item(mk_item(OP_READ, 0, 0, 0, 0, 255, 255));
        send_item(mk_item(OP_NONE, 170, 85, 204, 43690, 51, 204));  // ignored op
        send_item(mk_item(OP_READ, 0, 0, 0, 0, 85, 170));           // never written
        send_item(mk_item(OP_CLEAR, 85, 170, 51, 21845, 204, 51));
        send_item(mk_item(OP_READ, 0, 0, 0, 0, 255, 255));          // cleared, peak back to 0
        send_item(mk_item(OP_SPLAT, 128, 128, 128, 32768, 0, 0));
        send_item(mk_item(OP_READ, 0, 0, 0, 0, 128, 128));
        drain_results();

        // small negative x offset: slightly negative column truncates to 0
        cfg_write(CIDX_W'(REG_X_OFF), -16'sd1);
        send_item(mk_item(OP_SPLAT, 0, 3, 9, 900, 0, 0));
        send_item(mk_item(OP_SPLAT, 5, 3, 9, 901, 0, 0));
        send_item(mk_item(OP_READ, 0, 0, 0, 0, 0, 3));

        // random phases, each with its own register setting
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            drain_results();
            fill_regset(ph);
            for (int r = 0; r < NREGS; r++)
                cfg_write(CIDX_W'(r), regset[r]);
            cfg_write(CIDX_W'(NREGS + ph % NREGS), COEF_W'($urandom));  // unmapped index
            idle_en = (ph != 3 && ph != N_PHASES - 1);
            if (ph == 1 || ph == 5 || ph == N_PHASES - 1)
                send_item(mk_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom));
            repeat (phase_items[ph]) send_item(roll_item());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("voxel_max_projection_splat test passed");
        else
            $display("voxel_max_projection_splat test failed");
        $finish;
    end

endmodule

// File: filelist.f
hdl/vmps_pkg.sv
hdl/vmps_ctrl.sv
hdl/vmps_dp.sv
hdl/voxel_max_projection_splat.sv
tb/sv/voxel_max_projection_splat_tb.sv
